// ===== hdl/lcws_pkg.sv =====
// Shared constants and types for the load cell weight stabilizer.
// Fixed field widths, register map, reset values and fixed-point shifts.
// No dependencies.
`default_nettype none

package lcws_pkg;

	// default geometry
	localparam int WINDOW_LEN_DEF  = 12;
	localparam int SAMPLE_BITS_DEF = 24;

	// register and field widths
	localparam int GAIN_W     = 9;
	localparam int STEP_W     = 10;
	localparam int LIMIT_W    = 8;
	localparam int BAND_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_W      = 16;

	// fixed-point shifts: sample (1/16 g) to average (1/4096 g), gain in 1/256,
	// smoothed value (1/4096 g) to grams
	localparam int AVG_SH = 8;
	localparam int SM_SH  = 8;
	localparam int GR_SH  = 12;

	localparam int GAIN_FULL = 256;
	localparam int OUT_MAX   = 32767;
	localparam int OUT_MIN   = -32768;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMOOTHING_GAIN   = 3'd0,
		REG_DISPLAY_STEP     = 3'd1,
		REG_STABLE_STEP      = 3'd2,
		REG_AUTO_TARE_EN     = 3'd3,
		REG_DRIFT_CNT_LIMIT  = 3'd4,
		REG_DRIFT_BAND_LOW   = 3'd5,
		REG_DRIFT_BAND_HIGH  = 3'd6,
		REG_NEG_DRIFT_LIMIT  = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [GAIN_W-1:0]         RST_GAIN      = GAIN_W'(51);
	localparam logic [STEP_W-1:0]         RST_DISP_STEP = STEP_W'(1);
	localparam logic [STEP_W-1:0]         RST_STAB_STEP = STEP_W'(2);
	localparam logic                      RST_AUTO_TARE = 1'b1;
	localparam logic [LIMIT_W-1:0]        RST_LIMIT     = LIMIT_W'(20);
	localparam logic signed [BAND_W-1:0]  RST_BAND_LO   = BAND_W'(32);
	localparam logic signed [BAND_W-1:0]  RST_BAND_HI   = BAND_W'(112);
	localparam logic signed [BAND_W-1:0]  RST_NEG_LIM   = BAND_W'(-32);

endpackage : lcws_pkg

`default_nettype wire

// ===== hdl/load_cell_weight_stabilizer_top.sv =====
// Load cell weight stabilizer: tare, moving average, smoother, held weights.
// Depends on lcws_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction per sample:
//   raw_weight in 1/16 g and tare_request. Output channel (out_valid/
//   out_ready) returns exactly one transaction per sample: stable_weight,
//   display_weight (grams, saturated) and tare_fired.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   register selected by cfg_index from cfg_data; write only while idle.
// Timing:
//   One sample at a time. The result shows up once the sample has passed
//   through the bit-serial divider for the window average (one quotient bit
//   per cycle over the sum plus eight fraction bits) and the bit-serial
//   multiply by the 9-bit gain, and the next sample is taken from the
//   same cycle on in which that result shows up.
// Reset:
//   arst_n clears the window valid bits, sum, smoother, held weights, drift
//   count and loads the register defaults; the block is idle after it.
// Stall:
//   A finished result sits in the output register; a new sample is accepted
//   meanwhile, and its result waits in the last step until the old one is
//   taken.
`default_nettype none

module load_cell_weight_stabilizer_top
	import lcws_pkg::*;
#(
	parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// sample channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] raw_weight,
	input  wire logic                          tare_request,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [OUT_W-1:0]            stable_weight,
	output logic signed [OUT_W-1:0]            display_weight,
	output logic                               tare_fired,
	// configuration channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

	// derived widths
	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);          // fill count
	localparam int SLOT_W = $clog2(WINDOW_LEN);              // window address
	localparam int SUM_W  = SAMPLE_BITS + CNT_W;             // window sum
	localparam int DIV_W  = SUM_W + AVG_SH;                  // dividend bits
	localparam int DCT_W  = $clog2(DIV_W);
	localparam int AVG_W  = SAMPLE_BITS + AVG_SH + 1;        // average, 1/4096 g
	localparam int DIF_W  = AVG_W + 1;
	localparam int PRD_W  = DIF_W + GAIN_W;                  // smoother numerator
	localparam int MCT_W  = $clog2(GAIN_W);
	localparam int RND_W  = (AVG_W + 1 > GR_SH + OUT_W + 1) ? AVG_W + 1 : GR_SH + OUT_W + 1;
	localparam int GX_W   = RND_W - GR_SH;
	localparam int CMP_W  = (SAMPLE_BITS > BAND_W) ? SAMPLE_BITS : BAND_W;

	localparam logic [SLOT_W-1:0]       LAST_SLOT  = SLOT_W'(WINDOW_LEN - 1);
	localparam logic [CNT_W-1:0]        FULL_CNT   = CNT_W'(WINDOW_LEN);
	localparam logic [PRD_W-1:0]        SM_HALF    = PRD_W'(2 ** (SM_SH - 1));
	localparam logic [PRD_W-1:0]        SM_HALF_M  = PRD_W'(2 ** (SM_SH - 1) - 1);
	localparam logic [RND_W-1:0]        GR_HALF    = RND_W'(2 ** (GR_SH - 1));
	localparam logic [RND_W-1:0]        GR_HALF_M  = RND_W'(2 ** (GR_SH - 1) - 1);
	localparam logic signed [GX_W-1:0]  SAT_HI     = GX_W'(OUT_MAX);
	localparam logic signed [GX_W-1:0]  SAT_LO     = GX_W'(OUT_MIN);
	localparam logic [GAIN_W-1:0]       GAIN_ONE   = GAIN_W'(GAIN_FULL);
	localparam logic [LIMIT_W-1:0]      DRIFT_MAX  = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,    // tare clear, window write, old sample read
		ST_SUM,     // running sum and drift count
		ST_DINIT,   // load divider
		ST_DIV,     // one quotient bit per cycle
		ST_ROUND,   // round and sign the average
		ST_MINIT,   // load multiplier
		ST_MUL,     // one gain bit per cycle
		ST_NUM,     // add 256 * smoothed value
		ST_SMOOTH,  // divide by 256, rounded
		ST_GRAMS,   // divide by 4096, rounded and saturated
		ST_HOLD,    // held weight thresholds
		ST_DONE     // hand the result to the output register
	} state_t;

	state_t state_q;

	// configuration registers
	logic [GAIN_W-1:0]        gain_q;
	logic [STEP_W-1:0]        disp_step_q;
	logic [STEP_W-1:0]        stab_step_q;
	logic                     auto_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic signed [BAND_W-1:0] band_lo_q;
	logic signed [BAND_W-1:0] band_hi_q;
	logic signed [BAND_W-1:0] neg_lim_q;

	// filter state
	logic [WINDOW_LEN-1:0]    valid_q;
	logic [SLOT_W-1:0]        slot_q;
	logic                     full_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [AVG_W-1:0]  smooth_q;
	logic signed [OUT_W-1:0]  held_disp_q;
	logic signed [OUT_W-1:0]  held_stab_q;
	logic [LIMIT_W-1:0]       drift_q;

	// per-sample control
	logic                     tare_q;
	logic                     old_vld_q;
	logic [DCT_W-1:0]         dct_q;
	logic [MCT_W-1:0]         mct_q;

	// datapath registers
	logic signed [SAMPLE_BITS-1:0] raw_q;
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic [DIV_W-1:0]              div_q;
	logic [CNT_W-1:0]              rem_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          neg_q;
	logic [AVG_W-1:0]              avg_q;
	logic [DIF_W-1:0]              diff_q;
	logic [PRD_W-1:0]              prod_q;
	logic [GAIN_W-1:0]             gsh_q;
	logic signed [OUT_W-1:0]       grams_q;

	// output register
	logic                          out_valid_q;
	logic signed [OUT_W-1:0]       out_stab_q;
	logic signed [OUT_W-1:0]       out_disp_q;
	logic                          out_tare_q;

	// sample window memory
	logic signed [SAMPLE_BITS-1:0] win_mem [WINDOW_LEN];

	// combinational
	logic                     in_fire;
	logic                     tare_now;
	logic [SLOT_W-1:0]        wr_addr;
	logic [WINDOW_LEN-1:0]    valid_nxt;
	logic                     wrap;
	logic [CNT_W-1:0]         count_w;
	logic signed [SUM_W-1:0]  old_ext;
	logic signed [SUM_W-1:0]  sum_nxt;
	logic signed [CMP_W-1:0]  raw_c;
	logic                     drift_hit;
	logic [SUM_W-1:0]         sum_mag;
	logic [CNT_W:0]           rem2;
	logic [CNT_W:0]           rem_sub;
	logic                     q_bit;
	logic [CNT_W-1:0]         rem_nxt;
	logic                     rnd_up;
	logic [AVG_W-1:0]         amag;
	logic [AVG_W-1:0]         avg_nxt;
	logic [PRD_W-1:0]         diff_ext;
	logic [PRD_W-1:0]         mul_nxt;
	logic [PRD_W-1:0]         base_ext;
	logic [PRD_W-1:0]         sm_add;
	logic [RND_W-1:0]         sm_ext;
	logic [RND_W-1:0]         gr_add;
	logic signed [GX_W-1:0]   gx;
	logic signed [OUT_W-1:0]  gr_sat;
	logic [OUT_W:0]           dd_disp;
	logic [OUT_W:0]           dd_stab;
	logic [OUT_W:0]           ad_disp;
	logic [OUT_W:0]           ad_stab;
	logic                     upd_disp;
	logic                     upd_stab;
	logic                     out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// tare on request, or, with auto tare enabled, once the drift count reaches its limit
	assign tare_now = tare_request || (auto_q && (drift_q >= limit_q));

	// a tare restarts the window at slot zero
	assign wr_addr = tare_q ? '0 : slot_q;
	assign wrap    = (wr_addr == LAST_SLOT);

	always_comb begin
		for (int i = 0; i < WINDOW_LEN; i++) begin
			valid_nxt[i] = (!tare_q && valid_q[i]) || (wr_addr == SLOT_W'(i));
		end
	end

	// fill count, taken after the write has advanced the slot
	assign count_w = full_q ? FULL_CNT : CNT_W'(slot_q);

	// an entry not written since the last clear reads as zero
	assign old_ext = old_vld_q ? SUM_W'(rd_q) : '0;
	assign sum_nxt = sum_q + SUM_W'(raw_q) - old_ext;

	assign raw_c     = CMP_W'(raw_q);
	assign drift_hit = (auto_q && (raw_c > CMP_W'(band_lo_q)) && (raw_c < CMP_W'(band_hi_q)))
		|| (raw_c < CMP_W'(neg_lim_q));

	assign sum_mag = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;

	// restoring division step
	assign rem2    = {rem_q, div_q[DIV_W-1]};
	assign rem_sub = rem2 - {1'b0, cnt_q};
	assign q_bit   = (rem2 >= {1'b0, cnt_q});
	assign rem_nxt = q_bit ? rem_sub[CNT_W-1:0] : rem2[CNT_W-1:0];

	// round half away from zero on the magnitude
	assign rnd_up  = ({rem_q, 1'b0} >= {1'b0, cnt_q});
	assign amag    = div_q[AVG_W-1:0] + AVG_W'(rnd_up);
	assign avg_nxt = neg_q ? (AVG_W'(0) - amag) : amag;

	// numerator = 256 * S + g * (A - S), g shifted in MSB first
	assign diff_ext = {{GAIN_W{diff_q[DIF_W-1]}}, diff_q};
	assign mul_nxt  = {prod_q[PRD_W-2:0], 1'b0} + (gsh_q[GAIN_W-1] ? diff_ext : '0);
	assign base_ext = {{(PRD_W - AVG_W - SM_SH){smooth_q[AVG_W-1]}}, smooth_q, {SM_SH{1'b0}}};

	// arithmetic shift after adding half (half minus one when negative)
	assign sm_add = prod_q + (prod_q[PRD_W-1] ? SM_HALF_M : SM_HALF);
	assign sm_ext = RND_W'(smooth_q);
	assign gr_add = sm_ext + (smooth_q[AVG_W-1] ? GR_HALF_M : GR_HALF);
	assign gx     = gr_add[RND_W-1:GR_SH];

	always_comb begin
		priority if (gx > SAT_HI) begin
			gr_sat = OUT_W'(OUT_MAX);
		end else if (gx < SAT_LO) begin
			gr_sat = OUT_W'(OUT_MIN);
		end else begin
			gr_sat = gx[OUT_W-1:0];
		end
	end

	assign dd_disp  = {grams_q[OUT_W-1], grams_q} - {held_disp_q[OUT_W-1], held_disp_q};
	assign dd_stab  = {grams_q[OUT_W-1], grams_q} - {held_stab_q[OUT_W-1], held_stab_q};
	assign ad_disp  = dd_disp[OUT_W] ? ((OUT_W + 1)'(0) - dd_disp) : dd_disp;
	assign ad_stab  = dd_stab[OUT_W] ? ((OUT_W + 1)'(0) - dd_stab) : dd_stab;
	assign upd_disp = (ad_disp >= (OUT_W + 1)'(disp_step_q));
	assign upd_stab = (ad_stab >= (OUT_W + 1)'(stab_step_q));

	// result moves into the output register once the old one is gone
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// state, filter state, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_q      <= RST_GAIN;
			disp_step_q <= RST_DISP_STEP;
			stab_step_q <= RST_STAB_STEP;
			auto_q      <= RST_AUTO_TARE;
			limit_q     <= RST_LIMIT;
			band_lo_q   <= RST_BAND_LO;
			band_hi_q   <= RST_BAND_HI;
			neg_lim_q   <= RST_NEG_LIM;
			valid_q     <= '0;
			slot_q      <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			smooth_q    <= '0;
			held_disp_q <= '0;
			held_stab_q <= '0;
			drift_q     <= '0;
			tare_q      <= 1'b0;
			old_vld_q   <= 1'b0;
			dct_q       <= '0;
			mct_q       <= '0;
			out_valid_q <= 1'b0;
			out_stab_q  <= '0;
			out_disp_q  <= '0;
			out_tare_q  <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SMOOTHING_GAIN:  gain_q      <= cfg_data[GAIN_W-1:0];
					REG_DISPLAY_STEP:    disp_step_q <= cfg_data[STEP_W-1:0];
					REG_STABLE_STEP:     stab_step_q <= cfg_data[STEP_W-1:0];
					REG_AUTO_TARE_EN:    auto_q      <= cfg_data[0];
					REG_DRIFT_CNT_LIMIT: limit_q     <= cfg_data[LIMIT_W-1:0];
					REG_DRIFT_BAND_LOW:  band_lo_q   <= cfg_data[BAND_W-1:0];
					REG_DRIFT_BAND_HIGH: band_hi_q   <= cfg_data[BAND_W-1:0];
					REG_NEG_DRIFT_LIMIT: neg_lim_q   <= cfg_data[BAND_W-1:0];
				endcase
			end

			// drop the shown result once taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						tare_q  <= tare_now;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (tare_q) begin
						sum_q       <= '0;
						smooth_q    <= '0;
						held_disp_q <= '0;
						held_stab_q <= '0;
						drift_q     <= '0;
					end
					old_vld_q <= !tare_q && valid_q[wr_addr];
					valid_q   <= valid_nxt;
					slot_q    <= wrap ? '0 : wr_addr + 1'b1;
					full_q    <= (!tare_q && full_q) || wrap;
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					sum_q <= sum_nxt;
					if (drift_hit) begin
						if (drift_q != DRIFT_MAX) begin
							drift_q <= drift_q + 1'b1;
						end
					end else begin
						drift_q <= '0;
					end
					state_q <= ST_DINIT;
				end
				ST_DINIT: begin
					dct_q   <= DCT_W'(DIV_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dct_q == '0) begin
						state_q <= ST_ROUND;
					end else begin
						dct_q <= dct_q - 1'b1;
					end
				end
				ST_ROUND: begin
					state_q <= ST_MINIT;
				end
				ST_MINIT: begin
					mct_q   <= MCT_W'(GAIN_W - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mct_q == '0) begin
						state_q <= ST_NUM;
					end else begin
						mct_q <= mct_q - 1'b1;
					end
				end
				ST_NUM: begin
					state_q <= ST_SMOOTH;
				end
				ST_SMOOTH: begin
					smooth_q <= sm_add[AVG_W+SM_SH-1:SM_SH];
					state_q  <= ST_GRAMS;
				end
				ST_GRAMS: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (upd_disp) begin
						held_disp_q <= grams_q;
					end
					if (upd_stab) begin
						held_stab_q <= grams_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold here while the previous result is still waiting
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_stab_q  <= held_stab_q;
						out_disp_q  <= held_disp_q;
						out_tare_q  <= tare_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_q <= raw_weight;
		end
		unique case (state_q)
			ST_DINIT: begin
				div_q <= {sum_mag, {AVG_SH{1'b0}}};
				rem_q <= '0;
				cnt_q <= count_w;
				neg_q <= sum_q[SUM_W-1];
			end
			ST_DIV: begin
				div_q <= {div_q[DIV_W-2:0], q_bit};
				rem_q <= rem_nxt;
			end
			ST_ROUND: begin
				avg_q <= avg_nxt;
			end
			ST_MINIT: begin
				diff_q <= {avg_q[AVG_W-1], avg_q} - {smooth_q[AVG_W-1], smooth_q};
				prod_q <= '0;
				// gains above full scale act as full scale
				gsh_q  <= gain_q[GAIN_W-1] ? GAIN_ONE : gain_q;
			end
			ST_MUL: begin
				prod_q <= mul_nxt;
				gsh_q  <= {gsh_q[GAIN_W-2:0], 1'b0};
			end
			ST_NUM: begin
				prod_q <= prod_q + base_ext;
			end
			ST_GRAMS: begin
				grams_q <= gr_sat;
			end
			default: begin
			end
		endcase
	end

	// window memory: write the new sample, read the one it replaces
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q             <= win_mem[wr_addr];
			win_mem[wr_addr] <= raw_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign stable_weight  = out_stab_q;
	assign display_weight = out_disp_q;
	assign tare_fired     = out_tare_q;

endmodule : load_cell_weight_stabilizer_top

`default_nettype wire

// ===== hdl/lcws_checker.sv =====
// Port-level checks for the load cell weight stabilizer, bound to its top level.
// Depends on lcws_pkg and load_cell_weight_stabilizer_top.
`default_nettype none

module lcws_checker
	import lcws_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [OUT_W-1:0] stable_weight,
	input wire logic signed [OUT_W-1:0] display_weight,
	input wire logic                    tare_fired
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stable_weight)
			&& $stable(display_weight) && $stable(tare_fired))
		else $error("stalled result changed or dropped");

	// one sample at a time: busy right after a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while another is in work");

	// the block frees up only as it hands out a result
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("ready again without a result");

endmodule : lcws_checker

bind load_cell_weight_stabilizer_top lcws_checker u_lcws_checker (.*);

`default_nettype wire
